/* hw/rtl/base64_stream_encoder_top_assert.svh */
// ----------------------------------------------------------------------------
// Base64 encoder assertion macros
// Concurrent assertion shorthands. Each expects aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define B64E_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("b64e: same-cycle check failed");

// next-cycle implication
`define B64E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("b64e: next-cycle check failed");

`endif

/* hw/rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character codes and the sextet-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='

    // One encoded job: up to four characters from one input word.
    // cnt is the index of the final character (0..3).
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      cnt;
        logic            last;
    } job_t;

    function automatic logic [7:0] enc(input logic [5:0] sextet);
        logic [7:0] s8;
        logic [7:0] code;
        s8 = {2'b00, sextet};
        if (sextet < 6'd26) begin
            code = CHAR_UPPER_A + s8;
        end else if (sextet < 6'd52) begin
            code = CHAR_LOWER_A + (s8 - 8'd26);
        end else if (sextet < 6'd62) begin
            code = CHAR_DIGIT_0 + (s8 - 8'd52);
        end else if (sextet == 6'd62) begin
            code = CHAR_PLUS;
        end else begin
            code = CHAR_SLASH;
        end
        return code;
    endfunction

endpackage

/* hw/rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Takes input words, tracks group phase and leftover bits, builds jobs.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              in_ready,
    output logic              job_valid,
    output b64e_pkg::job_t    job,
    input  logic              job_ready
);
    import b64e_pkg::*;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic       accept;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;

    always_comb begin
        job        = '0;
        job.last   = in_last;
        phase_next = PH_0;
        left_next  = 4'd0;
        case (phase_reg)
            PH_1: begin
                job.chars[0] = enc({left_reg[1:0], in_byte[7:4]});
                if (in_last) begin
                    job.chars[1] = enc({in_byte[3:0], 2'b00});
                    job.chars[2] = CHAR_PAD;
                    job.cnt      = 2'd2;
                end else begin
                    job.cnt    = 2'd0;
                    phase_next = PH_2;
                    left_next  = in_byte[3:0];
                end
            end
            PH_2: begin
                job.chars[0] = enc({left_reg, in_byte[7:6]});
                job.chars[1] = enc(in_byte[5:0]);
                job.cnt      = 2'd1;
            end
            default: begin
                // phase 0 (unused code behaves the same, leftover ignored)
                job.chars[0] = enc(in_byte[7:2]);
                if (in_last) begin
                    job.chars[1] = enc({in_byte[1:0], 4'b0000});
                    job.chars[2] = CHAR_PAD;
                    job.chars[3] = CHAR_PAD;
                    job.cnt      = 2'd3;
                end else begin
                    job.cnt    = 2'd0;
                    phase_next = PH_1;
                    left_next  = {2'b00, in_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_0;
            left_reg  <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

/* hw/rtl/b64e_fifo.sv */
// ----------------------------------------------------------------------------
// b64e_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module b64e_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    input  b64e_pkg::job_t    wr_job,
    output logic              wr_ready,
    output logic              rd_valid,
    output b64e_pkg::job_t    rd_job,
    input  logic              rd_ready
);
    import b64e_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_en;
    logic       rd_en;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem[rd_ptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 2'd1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Serializes queued jobs into one character word per cycle while out_ready allows.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_assert.svh"

module b64e_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    input  b64e_pkg::job_t    job,
    output logic              job_ready,
    output logic              out_valid,
    output logic [7:0]        out_char,
    output logic              out_last,
    input  logic              out_ready
);
    import b64e_pkg::*;

    job_t       job_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       load;
    job_t       src;
    logic [1:0] src_idx;
    logic       src_final;

    assign out_free  = !out_valid_reg || out_ready;
    assign job_ready = out_free && !busy_reg;
    assign load      = out_free && (busy_reg || job_valid);
    assign src       = busy_reg ? job_reg : job;
    assign src_idx   = busy_reg ? idx_reg : 2'd0;
    assign src_final = (src_idx == src.cnt);

    always_ff @(posedge aclk) begin
        if (load && !src_final) begin
            job_reg <= src;
        end
        if (load) begin
            out_char_reg <= src.chars[src_idx];
            out_last_reg <= src.last && src_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            busy_reg      <= !src_final;
            idx_reg       <= src_final ? 2'd0 : src_idx + 2'd1;
        end else if (out_free) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    `B64E_ASSERT_SAME(a_idx_in_range, busy_reg, (idx_reg != 2'd0) && (idx_reg <= job_reg.cnt))
    `B64E_ASSERT_NEXT(a_final_frees, load && src_final, !busy_reg)
    `B64E_ASSERT_SAME(a_tlast_idle, out_valid_reg && out_last_reg, !busy_reg)

endmodule

/* hw/rtl/base64_stream_encoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Feed a message one byte word at a time on the s_axis side, with
// s_axis_tlast high on its final byte; every message has at least one byte.
// Characters leave on the m_axis side as ASCII words, one per cycle, and
// m_axis_tlast marks the final character of the encoded message (after any
// '=' pad). A byte makes one or two characters (two on the third byte of a
// group); the last byte adds the zero-filled tail character and padding so
// the message comes out as a multiple of four characters, at most four
// characters for one byte. The output port sets the pace: one character per
// cycle while m_axis_tready is high and characters are pending. The front
// stage takes a byte in the cycle it is offered whenever the two-entry job
// queue has room, so input and output stall independently; each byte's job
// passes through the queue and the registered output before its first
// character appears. Phase and leftover bits return to zero after each last
// byte, and reset (aresetn low at a clock edge) does the same.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    // input words
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // is_last
    // encoded characters
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // out_last
);
    import b64e_pkg::*;

    // front -> queue
    logic fq_valid;
    logic fq_ready;
    job_t fq_job;

    // queue -> back
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    // front: phase tracking and character lookup, one byte per cycle while the queue has room
    b64e_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .job_valid (fq_valid),
        .job       (fq_job),
        .job_ready (fq_ready)
    );

    // short queue decouples byte intake from character output
    b64e_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_job   (fq_job),
        .wr_ready (fq_ready),
        .rd_valid (qb_valid),
        .rd_job   (qb_job),
        .rd_ready (qb_ready)
    );

    // back: walks each job's characters into the registered output
    b64e_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job       (qb_job),
        .job_ready (qb_ready),
        .out_valid (m_axis_tvalid),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

endmodule

/* tb/sv/base64_stream_encoder_top_tb.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_top_tb
// Stream-level test of the base64 encoder: byte words go in, ASCII words
// come out and are checked one by one against a local encoder model.
// ----------------------------------------------------------------------------
// Directed messages cover the all-zero and all-one bytes and every tail
// length (zero, one and two bytes past a full group). Random messages
// follow under several idle/stall mixes. The receiver also holds off for a
// long stretch so the job queue fills and s_axis_tready drops. The sender
// also pauses until every expected character is back.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top_tb;
    import b64e_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 16;
    localparam int TIMEOUT_UNITS   = 4_000_000;   // watchdog timeout in time units, far past a slow run
    localparam int PHASE_BYTES     = 16;
    localparam int PRESSURE_BYTES  = 16;

    // ------------------------------------------------------------------------
    // Expected-character store with its own copy of the encoder state
    // ------------------------------------------------------------------------
    class b64_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } char_word_t;

        char_word_t  char_q[$];
        logic [3:0]  left_bits;    // unsent bits of the previous byte, right-aligned
        logic [1:0]  grp_phase;    // position of the next byte in its group
        int          mismatches;
        int          checked;
        string       alphabet;

        function new();
            alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            left_bits  = 4'd0;
            grp_phase  = 2'd0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function logic [7:0] sextet_char(input logic [5:0] s);
            return alphabet[s];
        endfunction

        function void push_char(input logic [7:0] ch, input logic last);
            char_word_t w;
            w.ch   = ch;
            w.last = last;
            char_q = {char_q, w};
        endfunction

        function int pending();
            return char_q.size();
        endfunction

        // Predict the characters one accepted byte word produces.
        function void note_word(input logic [7:0] b, input logic is_last);
            case (grp_phase)
                2'd1: begin
                    push_char(sextet_char({left_bits[1:0], b[7:4]}), 1'b0);
                    left_bits = b[3:0];
                    grp_phase = 2'd2;
                end
                2'd2: begin
                    push_char(sextet_char({left_bits, b[7:6]}), 1'b0);
                    // closes a full group: last flag lands here when no tail
                    push_char(sextet_char(b[5:0]), is_last);
                    left_bits = 4'd0;
                    grp_phase = 2'd0;
                end
                default: begin
                    push_char(sextet_char(b[7:2]), 1'b0);
                    left_bits = {2'b00, b[1:0]};
                    grp_phase = 2'd1;
                end
            endcase
            if (is_last) begin
                case (grp_phase)
                    2'd1: begin
                        push_char(sextet_char({left_bits[1:0], 4'b0000}), 1'b0);
                        push_char(CHAR_PAD, 1'b0);
                        push_char(CHAR_PAD, 1'b1);
                    end
                    2'd2: begin
                        push_char(sextet_char({left_bits, 2'b00}), 1'b0);
                        push_char(CHAR_PAD, 1'b1);
                    end
                    default: ;
                endcase
                // end of message: state back to start of group
                left_bits = 4'd0;
                grp_phase = 2'd0;
            end
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH char %0d: %s", checked, msg);
            mismatches++;
        endtask

        task check_char(input logic [7:0] ch, input logic last);
            char_word_t w;
            if (char_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word 0x%02h last=%0b", ch, last));
            end else begin
                w = char_q.pop_front();
                if (ch !== w.ch) begin
                    report_mismatch($sformatf("tdata 0x%02h, want 0x%02h", ch, w.ch));
                end
                if (last !== w.last) begin
                    report_mismatch($sformatf("tlast %0b, want %0b", last, w.last));
                end
            end
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;    // is_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_char
    logic       m_axis_tlast;            // out_last

    // traffic knobs, set by the main sequence
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;   // receiver hold-off, counted down by the receiver

    b64_scoreboard sb = new();

    base64_stream_encoder_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sender side. Tasks are entered just after a rising edge and return
    // at the rising edge where the word was taken; inputs move on falling
    // edges only.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_word(b, is_last);
    endtask

    // drop valid so a pause does not resend the last word
    task automatic sender_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // random messages, mostly short, now and then a longer one
    task automatic send_messages(input int n_bytes);
        int remaining;
        int len;
        remaining = n_bytes;
        while (remaining > 0) begin
            if ($urandom_range(9) == 0) len = $urandom_range(12, 7);
            else                        len = $urandom_range(6, 1);
            if (len > remaining) len = remaining;
            for (int i = 0; i < len; i++) begin
                send_word(8'($urandom_range(255)), i == len - 1);
            end
            remaining -= len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: tready set on falling edges, words taken at rising edges.
    // ------------------------------------------------------------------------
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_char(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_UNITS);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // directed messages: extremes and every tail length
        logic [7:0] dir_bytes[$] = '{
            8'h00,
            8'hFF,
            8'h00, 8'hFF,
            8'hFF, 8'h00,
            8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h00,
            8'hAA, 8'h55, 8'hF0, 8'h0F,
            8'hFC, 8'h03, 8'hCF, 8'h3F, 8'hC0
        };
        logic dir_last[$] = '{
            1'b1,
            1'b1,
            1'b0, 1'b1,
            1'b0, 1'b1,
            1'b0, 1'b0, 1'b1,
            1'b0, 1'b0, 1'b1,
            1'b0, 1'b0, 1'b0, 1'b1,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b1
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_bytes[i]) send_word(dir_bytes[i], dir_last[i]);

        // random traffic under each idle/stall mix
        send_messages(PHASE_BYTES);
        send_idle_pct = 80;
        send_messages(PHASE_BYTES);
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        send_messages(PHASE_BYTES);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        send_messages(PHASE_BYTES);

        // sender pauses until every character is back
        sender_idle();
        while (sb.pending() != 0) @(posedge aclk);

        // long receiver hold-off while the sender keeps offering words:
        // job queue fills and the input side has to stall
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_OFF_CYCLES;
        send_messages(PRESSURE_BYTES);

        // drain and let any stray word show up
        sender_idle();
        recv_stall_pct = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder_top.sv
tb/sv/base64_stream_encoder_top_tb.sv
